[src/range_sqrt_update_range_sum_core_defines.svh]
// Assertion macros for the range square-root / range-sum core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef RANGE_SQRT_UPDATE_RANGE_SUM_CORE_DEFINES_SVH
`define RANGE_SQRT_UPDATE_RANGE_SUM_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RSQ_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RSQ_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

[src/rsq_pkg.sv]
// Shared types and constants for the range square-root / range-sum core.
// No dependencies.
`default_nettype none
package rsq_pkg;
   localparam int DEPTH_DEF = 4096;
   localparam int BLOCK_DEF = 64;
   localparam int VAL_W = 40;
   localparam int TOT_W = 52;
   localparam int IDX_W = 12;
   localparam int LEN_W = 13;
   localparam int CMD_W = 2;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_ROOT = 2'd1,
      CMD_SUM  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // Classified job handed from the front end to the back end.
   typedef struct packed {
      cmd_type            cmd;
      logic [IDX_W-1:0]   lo;
      logic [IDX_W-1:0]   hi;
      logic [VAL_W-1:0]   value;
   } job_type;
endpackage
`default_nettype wire

[src/range_sqrt_update_range_sum_core.sv]
// Top level of the range square-root / range-sum core.
// Depends on rsq_pkg, rsq_front and rsq_back.
//
//  group | dir | tuser        | tdata / data fields (low bit up)
//  req   | in  | command[1:0] | first[11:0] last[23:12] value[63:24]
//  rsp   | out | -            | range_total[51:0]
//  csr   | in  | -            | length_in_use[12:0]
//
// After reset a clearing pass zeroes the values and block sums; the back end
// takes no word until it ends. Each element of a range square root passes
// through the iterative root unit, and inner blocks that are done are skipped;
// a sum reads its edge elements one by one and adds each inner block from its
// stored block sum. A result word waits in the back end until it is taken,
// and once the one-word queue ahead of it is full too, req_tready falls.
`default_nettype none
module range_sqrt_update_range_sum_core import rsq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int BLOCK = BLOCK_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // command
   input  wire logic [63:0] req_tdata,   // first, last, value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // range_total
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_data     // length_in_use
);
   logic [LEN_W-1:0] len_ff;
   logic             jv, jr;
   job_type          jb;
   logic [TOT_W-1:0] tot;

   assign csr_ready = 1'b1;
   // The written length is held within one and the depth.
   always_ff @(posedge clock) begin
      if (reset) len_ff <= LEN_W'(DEPTH);
      else if (csr_valid) begin
         if (csr_data == '0) len_ff <= LEN_W'(1);
         else if (int'(csr_data) > DEPTH) len_ff <= LEN_W'(DEPTH);
         else len_ff <= csr_data;
      end
   end

   rsq_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tuser), .in_first(req_tdata[11:0]),
      .in_last(req_tdata[23:12]), .in_value(req_tdata[63:24]),
      .length(len_ff), .job_valid(jv), .job_ready(jr), .job(jb));

   rsq_back #(.DEPTH(DEPTH), .BLOCK(BLOCK)) u_back (
      .clock, .reset, .job_valid(jv), .job_ready(jr), .job(jb),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_total(tot));

   assign rsp_tdata = {4'b0, tot};
endmodule
`default_nettype wire

[src/rsq_front.sv]
// Front end: accepts request words, clamps and orders endpoints, drops invalid ones.
// Depends on rsq_pkg.
`default_nettype none
module rsq_front import rsq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [CMD_W-1:0] in_cmd,
   input  wire logic [IDX_W-1:0] in_first,
   input  wire logic [IDX_W-1:0] in_last,
   input  wire logic [VAL_W-1:0] in_value,
   input  wire logic [LEN_W-1:0] length,
   output logic                  job_valid,
   input  wire logic             job_ready,
   output job_type               job
);
   logic             full_ff, full_in;
   job_type          job_ff, job_in;
   logic [IDX_W-1:0] lo_c, hi_c;
   logic [LEN_W-1:0] lmax;
   logic             keep;

   assign lmax = length - LEN_W'(1);
   assign in_ready = !full_ff || job_ready;
   assign job_valid = full_ff;
   assign job = job_ff;

   always_comb begin
      lo_c = ({1'b0, in_first} >= length) ? lmax[IDX_W-1:0] : in_first;
      hi_c = ({1'b0, in_last} >= length) ? lmax[IDX_W-1:0] : in_last;
      job_in.cmd = cmd_type'(in_cmd);
      job_in.value = in_value;
      if (in_cmd == CMD_LOAD) begin
         job_in.lo = in_first;
         job_in.hi = in_first;
         keep = {1'b0, in_first} < length;
      end else begin
         job_in.lo = (lo_c > hi_c) ? hi_c : lo_c;
         job_in.hi = (lo_c > hi_c) ? lo_c : hi_c;
         keep = in_cmd != CMD_NONE;
      end
      full_in = full_ff;
      if (job_ready) full_in = 1'b0;
      if (in_valid && in_ready && keep) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      if (in_valid && in_ready) job_ff <= job_in;
   end
endmodule
`default_nettype wire

[src/rsq_isqrt.sv]
// Iterative integer floor square root, one result bit per cycle.
// Depends on rsq_pkg.
`default_nettype none
module rsq_isqrt import rsq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAL_W-1:0] operand,
   output logic                  busy,
   output logic [VAL_W-1:0]      root
);
   localparam int STEPS = VAL_W / 2 + 1;
   localparam int CW = $clog2(STEPS + 1);
   logic [VAL_W+1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign busy = cnt_ff != '0;
   assign root = res_ff[VAL_W-1:0];

   always_comb begin
      v_in = v_ff; res_in = res_ff; bit_in = bit_ff; cnt_in = cnt_ff;
      if (start) begin
         v_in = {2'b0, operand};
         res_in = '0;
         bit_in = (VAL_W+2)'(1) << VAL_W;
         cnt_in = CW'(STEPS);
      end else if (busy) begin
         if (v_ff >= res_ff + bit_ff) begin
            v_in = v_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      v_ff <= v_in; res_ff <= res_in; bit_ff <= bit_in;
   end
endmodule
`default_nettype wire

[src/rsq_back.sv]
// Back end: value memory, block sums and flags, sequencer for load, root and sum.
// Depends on rsq_pkg, rsq_isqrt and the assertion macro header.
`default_nettype none
`include "range_sqrt_update_range_sum_core_defines.svh"
module rsq_back import rsq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int BLOCK = BLOCK_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [TOT_W-1:0]      out_total
);
   // BLOCK must be a power of two (the block does not enforce it); block numbers come from a shift.
   localparam int SH = $clog2(BLOCK);
   localparam int NBLK = (DEPTH + BLOCK - 1) / BLOCK;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW = (NBLK > 1) ? $clog2(NBLK) : 1;
   localparam int SW = VAL_W + SH;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001, ST_IDLE = 10'b0000000010, ST_READ = 10'b0000000100,
      ST_WAIT  = 10'b0000001000, ST_EXEC = 10'b0000010000, ST_ROOT = 10'b0000100000,
      ST_NEXT  = 10'b0001000000, ST_BLK  = 10'b0010000000, ST_BSEL = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   // Left edge span, right edge span, or a whole inner block.
   typedef enum logic [2:0] {
      PH_LEFT = 3'b001, PH_RIGHT = 3'b010, PH_INNER = 3'b100
   } phase_type;

   state_type        st_ff, st_in;
   phase_type        ph_ff, ph_in;
   job_type          job_ff;
   logic [AW-1:0]    idx_ff, idx_in;     // current element
   logic [AW-1:0]    end_ff, end_in;     // last element of current span
   logic [BW-1:0]    blk_ff, blk_in;     // current inner block
   logic             one_ff, one_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_ff;
   logic [SW-1:0]    bsum [NBLK];
   logic [SW-1:0]    bs_ff;
   logic [NBLK-1:0]  done_ff;
   logic             dn_ff;
   logic [AW-1:0]    clr_ff;
   logic             wr_en;
   logic [VAL_W-1:0] wr_data;
   logic [BW-1:0]    cur_blk, bx, by, jbx, jby;
   logic [AW-1:0]    by_start, blk_start, blk_end, j_end;
   logic             sq_start, sq_busy;
   logic [VAL_W-1:0] sq_root;

   rsq_isqrt u_sqrt (.clock, .reset, .start(sq_start), .operand(rd_ff),
                     .busy(sq_busy), .root(sq_root));

   assign job_ready = st_ff == ST_IDLE;
   assign out_valid = st_ff == ST_OUT;
   assign out_total = tot_ff;
   assign bx = BW'(job_ff.lo >> SH);
   assign by = BW'(job_ff.hi >> SH);
   assign jbx = BW'(job.lo >> SH);
   assign jby = BW'(job.hi >> SH);
   assign cur_blk = BW'(idx_ff >> SH);
   assign by_start = AW'(int'(by) << SH);
   assign blk_start = AW'(int'(blk_ff) << SH);
   assign blk_end = AW'(((int'(blk_ff) + 1) << SH) - 1);
   assign j_end = (jbx == jby) ? AW'(job.hi) : AW'(((int'(jbx) + 1) << SH) - 1);

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; end_in = end_ff; ph_in = ph_ff; blk_in = blk_ff;
      one_in = one_ff; tot_in = tot_ff; sq_start = 1'b0; wr_en = 1'b0;
      wr_data = job_ff.value;
      case (st_ff)
         ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) st_in = ST_IDLE;
         ST_IDLE: if (job_valid) begin
            st_in = ST_READ; tot_in = '0; ph_in = PH_LEFT; one_in = 1'b1;
            idx_in = AW'(job.lo);
            end_in = j_end;
         end
         ST_READ: st_in = ST_WAIT;
         ST_WAIT: st_in = ST_EXEC;
         ST_EXEC: begin
            case (job_ff.cmd)
               CMD_LOAD: begin wr_en = 1'b1; st_in = ST_IDLE; end
               CMD_ROOT: begin sq_start = 1'b1; st_in = ST_ROOT; end
               default: begin
                  tot_in = tot_ff + TOT_W'(rd_ff);
                  st_in = ST_NEXT;
               end
            endcase
         end
         ST_ROOT: if (!sq_busy) begin
            wr_en = 1'b1; wr_data = sq_root;
            if (sq_root != VAL_W'(1)) one_in = 1'b0;
            st_in = ST_NEXT;
         end
         ST_NEXT: begin
            // advance to the next element, span or inner block
            if (idx_ff != end_ff) begin
               idx_in = idx_ff + AW'(1); st_in = ST_READ;
            end else if (ph_ff == PH_LEFT && bx != by) begin
               ph_in = PH_RIGHT; idx_in = by_start; end_in = AW'(job_ff.hi);
               st_in = ST_READ;
            end else if (ph_ff == PH_RIGHT) begin
               ph_in = PH_INNER; blk_in = bx + BW'(1); st_in = ST_BLK;
            end else if (ph_ff == PH_INNER) begin
               blk_in = blk_ff + BW'(1); st_in = ST_BLK;
            end else begin
               st_in = (job_ff.cmd == CMD_SUM) ? ST_OUT : ST_IDLE;
            end
         end
         // The block sum and done flag of blk_ff are read here, used in ST_BSEL.
         ST_BLK: begin
            if (blk_ff == by) st_in = (job_ff.cmd == CMD_SUM) ? ST_OUT : ST_IDLE;
            else st_in = ST_BSEL;
         end
         ST_BSEL: begin
            if (job_ff.cmd == CMD_SUM) begin
               tot_in = tot_ff + TOT_W'(bs_ff);
               blk_in = blk_ff + BW'(1); st_in = ST_BLK;
            end else if (dn_ff) begin
               blk_in = blk_ff + BW'(1); st_in = ST_BLK;
            end else begin
               one_in = 1'b1; idx_in = blk_start; end_in = blk_end; st_in = ST_READ;
            end
         end
         ST_OUT: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; done_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (wr_en && job_ff.cmd == CMD_LOAD) done_ff[cur_blk] <= 1'b0;
         else if (st_ff == ST_NEXT && ph_ff == PH_INNER && idx_ff == end_ff)
            done_ff[blk_ff] <= one_ff;
      end
      idx_ff <= idx_in; end_ff <= end_in; ph_ff <= ph_in; blk_ff <= blk_in;
      one_ff <= one_in; tot_ff <= tot_in;
      if (st_ff == ST_IDLE && job_valid) job_ff <= job;
      if (st_ff == ST_READ) begin
         rd_ff <= mem[idx_ff];
         bs_ff <= bsum[cur_blk];
      end else if (st_ff == ST_BLK) begin
         bs_ff <= bsum[blk_ff];
         dn_ff <= done_ff[blk_ff];
      end
      if (st_ff == ST_CLEAR) mem[clr_ff] <= '0;
      else if (wr_en) mem[idx_ff] <= wr_data;
      if (st_ff == ST_CLEAR) begin
         if (int'(clr_ff) < NBLK) bsum[clr_ff[BW-1:0]] <= '0;
      end else if (wr_en) begin
         bsum[cur_blk] <= bs_ff - SW'(rd_ff) + SW'(wr_data);
      end
   end

   `RSQ_ASSERT_IMP(a_out_only_sum, clock, reset, out_valid, job_ff.cmd == CMD_SUM)
   `RSQ_ASSERT_NEXT(a_out_holds, clock, reset, out_valid && !out_ready,
                    out_valid && $stable(out_total))
   `RSQ_ASSERT_IMP(a_no_take_busy, clock, reset, job_ready, !sq_busy)
endmodule
`default_nettype wire

[tb/sv/range_sqrt_update_range_sum_core_tb.sv]
// Self-checking testbench for the range square-root / range-sum core.
// Needs rsq_pkg and the core; drives it through its request, response and length ports.
`timescale 1ns / 1ps
module range_sqrt_update_range_sum_core_tb;
   import rsq_pkg::*;

   // One request word as the core sees it on req_tuser and req_tdata.
   typedef struct packed {
      logic [39:0] value;
      logic [11:0] last;
      logic [11:0] first;
      cmd_type     cmd;
   } req_word_type;

   localparam int NBLK = DEPTH_DEF / BLOCK_DEF;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SQUEEZE_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;

   range_sqrt_update_range_sum_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Words still to be offered, and sums the core still owes us.
   req_word_type pending_words[$];
   logic [51:0]  expected_totals[$];
   int           mismatches = 0;

   // Our own copy of the array, its block sums, done flags and the length.
   logic [39:0] elem_val [DEPTH_DEF];
   logic [63:0] blk_sum  [NBLK];
   bit          blk_done [NBLK];
   int          len_cfg = DEPTH_DEF;

   // Accepted request words as counted by the monitor, and as seen by the sender.
   int req_accepts = 0;
   int req_seen = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit squeeze = 1'b0;
   bit squeezed = 1'b0;

   task automatic report(input string what);
      mismatches++;
      $display("[%0t] %s", $time, what);
   endtask

   // Exact floor square root, built one result bit at a time from the top.
   function automatic logic [39:0] floor_root(input logic [39:0] v);
      logic [63:0] r;
      logic [63:0] trial;
      r = 0;
      for (int k = 19; k >= 0; k--) begin
         trial = r | (64'd1 << k);
         if (trial * trial <= {24'd0, v}) r = trial;
      end
      return r[39:0];
   endfunction

   function automatic void root_elem(input int i);
      logic [39:0] r;
      r = floor_root(elem_val[i]);
      blk_sum[i / BLOCK_DEF] = blk_sum[i / BLOCK_DEF] - elem_val[i] + r;
      elem_val[i] = r;
   endfunction

   function automatic logic [63:0] span_total(input int lo, input int hi);
      logic [63:0] t;
      t = 0;
      for (int i = lo; i <= hi; i++) t += elem_val[i];
      return t;
   endfunction

   function automatic int clamp_idx(input logic [11:0] raw);
      return (int'(raw) >= len_cfg) ? len_cfg - 1 : int'(raw);
   endfunction

   // Updates the array for one accepted word and queues the sum it owes.
   function automatic void apply_request(input req_word_type w);
      int lo, hi, bx, by, tmp;
      bit all_one;
      logic [63:0] t;
      case (w.cmd)
         CMD_LOAD: begin
            if (int'(w.first) < len_cfg) begin
               bx = int'(w.first) / BLOCK_DEF;
               blk_sum[bx] = blk_sum[bx] - elem_val[w.first] + w.value;
               elem_val[w.first] = w.value;
               blk_done[bx] = 1'b0;
            end
         end
         CMD_ROOT, CMD_SUM: begin
            lo = clamp_idx(w.first);
            hi = clamp_idx(w.last);
            if (lo > hi) begin
               tmp = lo; lo = hi; hi = tmp;
            end
            bx = lo / BLOCK_DEF;
            by = hi / BLOCK_DEF;
            if (w.cmd == CMD_ROOT) begin
               if (bx == by) begin
                  for (int i = lo; i <= hi; i++) root_elem(i);
               end else begin
                  for (int i = lo; i < (bx + 1) * BLOCK_DEF; i++) root_elem(i);
                  for (int i = by * BLOCK_DEF; i <= hi; i++) root_elem(i);
                  for (int b = bx + 1; b < by; b++) begin
                     if (!blk_done[b]) begin
                        all_one = 1'b1;
                        for (int i = b * BLOCK_DEF; i < (b + 1) * BLOCK_DEF; i++) begin
                           root_elem(i);
                           if (elem_val[i] != 40'd1) all_one = 1'b0;
                        end
                        blk_done[b] = all_one;
                     end
                  end
               end
            end else begin
               if (bx == by) begin
                  t = span_total(lo, hi);
               end else begin
                  t = span_total(lo, (bx + 1) * BLOCK_DEF - 1) + span_total(by * BLOCK_DEF, hi);
                  for (int b = bx + 1; b < by; b++) t += blk_sum[b];
               end
               expected_totals.push_back(t[51:0]);
            end
         end
         default: ;
      endcase
   endfunction

   // Sender: after a word is taken, valid drops before the next word goes out,
   // possibly after a random gap.
   always @(negedge clock) begin
      logic nv;
      logic taken;
      req_word_type w;
      nv = req_tvalid;
      taken = req_accepts != req_seen;
      if (taken) begin
         nv = 1'b0;
         req_seen <= req_accepts;
         case ($urandom_range(0, 19))
            0:             req_gap <= $urandom_range(20, 80);
            1, 2, 3, 4, 5: req_gap <= $urandom_range(1, 3);
            default:       req_gap <= 0;
         endcase
      end else if (!nv && req_gap > 0) begin
         req_gap <= req_gap - 1;
      end
      if (!nv && !taken && req_gap == 0 && !reset && pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_tuser <= w.cmd;
         req_tdata <= {w.value, w.last, w.first};
         nv = 1'b1;
      end
      req_tvalid <= nv;
   end

   // Receiver: mostly ready, with short and long stalls, plus one long
   // hold-off on request so that the core backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (squeeze && !squeezed) begin
         squeezed <= 1'b1;
         rsp_stall <= SQUEEZE_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               rsp_stall <= $urandom_range(20, 80);
               rsp_tready <= 1'b0;
            end
            1, 2, 3, 4: begin
               rsp_stall <= $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Monitor: predicts on each accepted request word, checks each response word.
   always @(posedge clock) begin
      logic [51:0] want;
      req_word_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_accepts <= req_accepts + 1;
            w.cmd = cmd_type'(req_tuser);
            w.first = req_tdata[11:0];
            w.last = req_tdata[23:12];
            w.value = req_tdata[63:24];
            apply_request(w);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_totals.size() == 0) begin
               report($sformatf("unexpected range_total %0h", rsp_tdata[51:0]));
            end else begin
               want = expected_totals.pop_front();
               if (rsp_tdata[51:0] !== want)
                  report($sformatf("range_total %0h, want %0h", rsp_tdata[51:0], want));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_data == 13'd0) len_cfg = 1;
            else if (csr_data > DEPTH_DEF) len_cfg = DEPTH_DEF;
            else len_cfg = int'(csr_data);
         end
      end
   end

   // Watchdog: ends the run if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      static int idle_cycles = 0;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_word(input cmd_type c, input int f, input int l, input logic [39:0] v);
      req_word_type w;
      w.cmd = c;
      w.first = f[11:0];
      w.last = l[11:0];
      w.value = v;
      pending_words.push_back(w);
   endtask

   function automatic logic [39:0] rand_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return 40'({$urandom, $urandom});
         3, 4:    return 40'($urandom_range(0, 20));
         5, 6:    return 40'd1;
         7:       return 40'd0;
         8:       return 40'hFF_FFFF_FFFF;
         default: return 40'($urandom_range(0, 1000000));
      endcase
   endfunction

   // Random words around a hot window so that repeated roots drive values
   // down to one and blocks become done; a few reach anywhere in the index
   // space, beyond the length too.
   task automatic push_random(input int count, input int len);
      int hot_base, hot_w, f, l, span;
      cmd_type c;
      hot_w = (len < 320) ? len : 320;
      hot_base = $urandom_range(0, len - hot_w);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 49))
            0:                    c = CMD_NONE;
            1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19:
                                  c = CMD_LOAD;
            20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34:
                                  c = CMD_ROOT;
            default:              c = CMD_SUM;
         endcase
         if ($urandom_range(0, 29) == 0) begin
            f = $urandom_range(0, 4095);
            l = $urandom_range(0, 4095);
            // A full-width root is very slow; with a long length such roots shrink to one element.
            if (c == CMD_ROOT && len > 400) l = f;
         end else begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hot_w - 1)
                                                : $urandom_range(0, 40);
            f = hot_base + $urandom_range(0, hot_w - 1);
            l = f + span;
            if (l > hot_base + hot_w - 1) l = hot_base + hot_w - 1;
            if ($urandom_range(0, 1)) begin
               span = f; f = l; l = span;
            end
         end
         push_word(c, f, l, rand_value());
      end
      // A closing sum guarantees that the core has finished all earlier work.
      push_word(CMD_SUM, 0, 4095, 40'd0);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_totals.size() != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_length(input logic [12:0] len);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      for (int i = 0; i < DEPTH_DEF; i++) elem_val[i] = '0;
      for (int b = 0; b < NBLK; b++) begin
         blk_sum[b] = '0;
         blk_done[b] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset length: extreme indices and values,
      // swapped endpoints, roots of single elements and across inner
      // blocks, the ignored command and a full-range root.
      write_length(13'd4096);
      push_word(CMD_SUM, 0, 4095, 40'd0);
      push_word(CMD_LOAD, 0, 0, 40'hFF_FFFF_FFFF);
      push_word(CMD_LOAD, 4095, 0, 40'hFF_FFFF_FFFF);
      push_word(CMD_LOAD, 63, 4095, 40'h80_0000_0001);
      push_word(CMD_LOAD, 64, 0, 40'd1);
      push_word(CMD_SUM, 4095, 0, 40'd0);
      push_word(CMD_SUM, 0, 0, 40'd0);
      push_word(CMD_ROOT, 0, 0, 40'd0);
      push_word(CMD_SUM, 0, 63, 40'd0);
      push_word(CMD_NONE, 0, 4095, 40'hFF_FFFF_FFFF);
      push_word(CMD_ROOT, 200, 10, 40'd0);
      push_word(CMD_SUM, 10, 200, 40'd0);
      push_word(CMD_ROOT, 0, 4095, 40'd0);
      push_word(CMD_SUM, 4095, 4095, 40'd0);
      push_word(CMD_SUM, 0, 4095, 40'd0);
      drain();

      // A written length of zero is taken as one: everything clamps to index 0
      // and loads elsewhere are dropped.
      write_length(13'd0);
      push_word(CMD_LOAD, 1, 0, 40'd77);
      push_word(CMD_SUM, 4095, 4095, 40'd0);
      push_random(40, 1);
      drain();

      // A length above the array size is taken as the full array.
      write_length(13'h1FFF);
      push_random(450, DEPTH_DEF);
      drain();

      write_length(13'd130);
      push_random(450, 130);
      drain();

      // Long receiver hold-off while sums keep arriving.
      write_length(13'd2000);
      squeeze = 1'b1;
      for (int n = 0; n < 30; n++)
         push_word(CMD_SUM, $urandom_range(0, 1999), $urandom_range(0, 1999), 40'd0);
      push_random(450, 2000);
      drain();

      write_length(13'd1);
      push_random(30, 1);
      drain();

      write_length(13'd4096);
      push_random(450, DEPTH_DEF);
      drain();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
